### rtl/bnc_pkg.sv
// Shared constants, item types and a helper function of the binary 3x3 convolution block.
package bnc_pkg;

  localparam int IMAGE_WIDTH  = 28;
  localparam int IN_CHANNELS  = 3;
  localparam int OUT_CHANNELS = 3;

  localparam int ROW_W      = 28;              // width of one packed input row field
  localparam int IDX_W      = 5;               // row and column index width
  localparam int CNT_W      = 5;               // match count width
  localparam int WEIGHT_W   = 27;
  localparam int NUM_WEIGHT = 3;
  localparam int WIN_BITS   = 9 * IN_CHANNELS;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [IDX_W-1:0] COL_LAST = IDX_W'(IMAGE_WIDTH - 3);
  localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(IMAGE_WIDTH - 1);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WEIGHT_0 = 2'd0;
  localparam logic [1:0] REG_WEIGHT_1 = 2'd1;
  localparam logic [1:0] REG_WEIGHT_2 = 2'd2;

  typedef struct packed {
    logic [ROW_W-1:0] row_bits_ch0;
    logic [ROW_W-1:0] row_bits_ch1;
    logic [ROW_W-1:0] row_bits_ch2;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic [CNT_W-1:0] match_count_0;
    logic [CNT_W-1:0] match_count_1;
    logic [CNT_W-1:0] match_count_2;
    logic [2:0]       activations;
    logic             last_in_row;
  } out_item_t;

  typedef logic [NUM_WEIGHT-1:0][WEIGHT_W-1:0] weights_t;

  // One window column position handed from the row shifters to the evaluator.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [WIN_BITS-1:0] bits;
  } win_t;

  // Counts ones three bits at a time so the adder chain stays short.
  function automatic logic [CNT_W-1:0] popcount(input logic [WIN_BITS-1:0] v);
    logic [CNT_W-1:0] total;
    logic [1:0]       part;
    total = '0;
    for (int g = 0; g < WIN_BITS / 3; g++) begin
      part  = 2'(v[3*g]) + 2'(v[3*g+1]) + 2'(v[3*g+2]);
      total = total + CNT_W'(part);
    end
    return total;
  endfunction

endpackage

### rtl/bnc_cfg.sv
// Configuration register file holding the three binary kernels behind an APB-style port.
module bnc_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bnc_pkg::ADDR_W-1:0] paddr,
  input  logic [bnc_pkg::DATA_W-1:0] pwdata,
  output logic [bnc_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output bnc_pkg::weights_t         weights
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      weights <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        bnc_pkg::REG_WEIGHT_0: weights[0] <= pwdata[bnc_pkg::WEIGHT_W-1:0];
        bnc_pkg::REG_WEIGHT_1: weights[1] <= pwdata[bnc_pkg::WEIGHT_W-1:0];
        bnc_pkg::REG_WEIGHT_2: weights[2] <= pwdata[bnc_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bnc_pkg::REG_WEIGHT_0: prdata = bnc_pkg::DATA_W'(weights[0]);
      bnc_pkg::REG_WEIGHT_1: prdata = bnc_pkg::DATA_W'(weights[1]);
      bnc_pkg::REG_WEIGHT_2: prdata = bnc_pkg::DATA_W'(weights[2]);
      default:               prdata = '0;
    endcase
  end

endmodule

### rtl/bnc_rowshift.sv
// Line store, row counter and per-row shift registers that step the 3x3 window one column a cycle unless stalled.
module bnc_rowshift (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bnc_pkg::in_item_t in_data,
  input  logic              take,
  output bnc_pkg::win_t     win
);

  localparam int W = bnc_pkg::IMAGE_WIDTH;

  logic                      busy;
  logic [bnc_pkg::IDX_W-1:0] col;
  logic [bnc_pkg::IDX_W-1:0] row_counter;
  logic [bnc_pkg::IDX_W-1:0] out_row;
  logic                      accept;

  logic [bnc_pkg::ROW_W-1:0] in_rows [3];
  logic [W-1:0]              prev2 [bnc_pkg::IN_CHANNELS];
  logic [W-1:0]              prev1 [bnc_pkg::IN_CHANNELS];
  // Shifters per channel: oldest row, middle row, newest row.
  logic [W-1:0]              sr [bnc_pkg::IN_CHANNELS][3];

  assign in_rows[0] = in_data.row_bits_ch0;
  assign in_rows[1] = in_data.row_bits_ch1;
  assign in_rows[2] = in_data.row_bits_ch2;

  // A new row may be taken in the same cycle the last column leaves.
  assign in_ready = !busy || (take && col == bnc_pkg::COL_LAST);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      col         <= '0;
      row_counter <= '0;
    end else if (accept) begin
      busy        <= (row_counter >= bnc_pkg::IDX_W'(2));
      col         <= '0;
      row_counter <= (row_counter == bnc_pkg::ROW_LAST) ? '0
                                                        : row_counter + bnc_pkg::IDX_W'(1);
    end else if (take) begin
      if (col == bnc_pkg::COL_LAST) begin
        busy <= 1'b0;
      end else begin
        col <= col + bnc_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_row <= row_counter - bnc_pkg::IDX_W'(2);
      for (int c = 0; c < bnc_pkg::IN_CHANNELS; c++) begin
        prev2[c] <= prev1[c];
        prev1[c] <= in_rows[c][W-1:0];
        sr[c][0] <= prev2[c];
        sr[c][1] <= prev1[c];
        sr[c][2] <= in_rows[c][W-1:0];
      end
    end else if (take) begin
      for (int c = 0; c < bnc_pkg::IN_CHANNELS; c++) begin
        for (int r = 0; r < 3; r++) begin
          sr[c][r] <= {sr[c][r][W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    win.valid = busy;
    win.last  = (col == bnc_pkg::COL_LAST);
    win.row   = out_row;
    win.col   = col;
    win.bits  = '0;
    for (int c = 0; c < bnc_pkg::IN_CHANNELS; c++) begin
      for (int r = 0; r < 3; r++) begin
        win.bits[bnc_pkg::WIN_BITS-1-9*c-3*r -: 3] = sr[c][r][W-1 -: 3];
      end
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> col <= bnc_pkg::COL_LAST)
    else $error("column index ran past the last output column");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_counter <= bnc_pkg::ROW_LAST)
    else $error("row counter ran past the image height");

  a_start: assert property (@(posedge clk) disable iff (rst)
    accept && row_counter >= bnc_pkg::IDX_W'(2) |=> busy && col == '0)
    else $error("a third or later row did not start its column sweep");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    take && col == bnc_pkg::COL_LAST && !accept |=> !busy)
    else $error("sweep did not end after the last column");

endmodule

### rtl/bnc_eval.sv
// XNOR and popcount of one window against each kernel, with the registered result stage.
module bnc_eval (
  input  logic               clk,
  input  logic               rst,
  input  bnc_pkg::win_t      win,
  input  bnc_pkg::weights_t  weights,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output bnc_pkg::out_item_t out_data
);

  logic [bnc_pkg::CNT_W-1:0] cnt [3];
  logic [2:0]                act;
  bnc_pkg::out_item_t        item_next;

  assign take = win.valid && (!out_valid || out_ready);

  always_comb begin
    for (int oc = 0; oc < 3; oc++) begin
      cnt[oc] = '0;
      act[oc] = 1'b0;
      if (oc < bnc_pkg::OUT_CHANNELS) begin
        cnt[oc] = bnc_pkg::popcount(~(win.bits ^ weights[oc][bnc_pkg::WIN_BITS-1:0]));
        act[oc] = ({1'b0, cnt[oc], 1'b0} > (bnc_pkg::CNT_W + 2)'(bnc_pkg::WIN_BITS));
      end
    end
    item_next.out_row       = win.row;
    item_next.out_col       = win.col;
    item_next.match_count_0 = cnt[0];
    item_next.match_count_1 = cnt[1];
    item_next.match_count_2 = cnt[2];
    item_next.activations   = act;
    item_next.last_in_row   = win.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= item_next;
    end
  end

  a_capture: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid && out_data.out_col == $past(win.col))
    else $error("result stage did not capture the current column");

endmodule

### rtl/binary_conv3x3_xnor_popcount.sv
// Top level of the binarized 3x3 XNOR-popcount convolution block.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    in_data  (one image row, three channels)
//  out      output     out_valid/out_ready  out_data (one output column result)
//  cfg      input      psel/penable/pwrite  paddr, pwdata, prdata (three kernels)
//
// The first two rows of an image are stored and give no result.
// Every later row gives 26 column results: the row shifters step one column per cycle.
// A stalled output holds the shifters; a new row is taken as the last column leaves.
// Reset clears the row counter and handshake state; the line store is filled by
// the first two rows of each image before it is read.
module binary_conv3x3_xnor_popcount (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bnc_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bnc_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bnc_pkg::ADDR_W-1:0] paddr,
  input  logic [bnc_pkg::DATA_W-1:0] pwdata,
  output logic [bnc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  bnc_pkg::weights_t weights;
  bnc_pkg::win_t     win;
  logic              take;

  bnc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .weights (weights)
  );

  bnc_rowshift u_rowshift (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (take),
    .win      (win)
  );

  bnc_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .weights   (weights),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
